// ----- src/cdzr_pkg.sv -----
// Shared constants, types and address helper for the zero-padded conv2d/ReLU core.
package cdzr_pkg;

    localparam int MAX_SIDE        = 64;
    localparam int MAX_KERNEL_SIDE = 11;
    localparam int MAX_KERNELS     = 8;
    localparam int TAPS_PER_KERNEL = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
    localparam int TAP_DEPTH       = MAX_KERNELS * TAPS_PER_KERNEL;
    localparam int PIX_DEPTH       = MAX_SIDE * MAX_SIDE;

    localparam int PIX_AW  = $clog2(PIX_DEPTH);
    localparam int TAP_AW  = $clog2(TAP_DEPTH);
    localparam int KIDX_W  = 3;
    localparam int POS_W   = 6;
    localparam int TIDX_W  = 4;
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = PIX_W + 1 + COEF_W;
    // 121 taps of at most 256 * 2^15 in magnitude stay below 2^30
    localparam int ACC_W   = 32;
    localparam int ACT_W   = 31;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_AMOUNT  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_PIXEL  = 2'd0,
        OP_LOAD_WEIGHT = 2'd1,
        OP_LOAD_BIAS   = 2'd2,
        OP_COMPUTE     = 2'd3
    } op_t;

    typedef struct packed {
        logic                     pix_we;
        logic                     w_we;
        logic                     b_we;
        logic [PIX_AW-1:0]        pix_addr;
        logic [TAP_AW-1:0]        tap_addr;
        logic signed [COEF_W-1:0] data;
    } store_wr_t;

    function automatic logic [TAP_AW-1:0] tap_addr(
        input logic [KIDX_W-1:0] k,
        input logic [TIDX_W-1:0] h,
        input logic [TIDX_W-1:0] l
    );
        return TAP_AW'(k) * TAP_AW'(TAPS_PER_KERNEL)
             + TAP_AW'(h) * TAP_AW'(MAX_KERNEL_SIDE)
             + TAP_AW'(l);
    endfunction

endpackage

// ----- src/conv2d_zero_pad_relu_core.sv -----
// Zero-padded 2-D convolution with per-tap bias and ReLU, one shared MAC under a tap sequencer.
//
// Load beats (pixel, weight, bias) leave the input side ready. A compute beat for an output
// inside the map holds the input side not ready while the kernel taps pass one by one
// through the single multiply-accumulate unit, while its read and product registers drain,
// and until the sum is moved into the output register (a move that waits while the output
// side stalls). A compute beat outside the map gives no result. After reset the weight and
// bias stores are cleared by a sweep over all 968 entries, one entry per cycle, during which
// no input beat is taken; configuration writes are taken at any time.
module conv2d_zero_pad_relu_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cdzr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cdzr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_operation,
    input  logic [cdzr_pkg::KIDX_W-1:0]            s_kernel_index,
    input  logic [cdzr_pkg::POS_W-1:0]             s_row_index,
    input  logic [cdzr_pkg::POS_W-1:0]             s_col_index,
    input  logic signed [cdzr_pkg::COEF_W-1:0]     s_load_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [cdzr_pkg::KIDX_W-1:0]            m_out_kernel,
    output logic [cdzr_pkg::POS_W-1:0]             m_out_row,
    output logic [cdzr_pkg::POS_W-1:0]             m_out_col,
    output logic [cdzr_pkg::ACT_W-1:0]             m_activation
);
    import cdzr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]        image_side_reg;
    logic [TIDX_W-1:0] kernel_side_reg;
    logic [6:0]        pad_reg;

    logic [KIDX_W-1:0] k_reg, k_next;
    logic [POS_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [TIDX_W-1:0] h_reg, h_next, l_reg, l_next;
    logic [TAP_AW-1:0] row_base_reg, row_base_next;
    logic              drain_reg, drain_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_pix_in_reg, s1_pix_in_next;

    logic              m_valid_reg, m_valid_next;
    logic [KIDX_W-1:0] m_kernel_reg;
    logic [POS_W-1:0]  m_row_reg, m_col_reg;
    logic [ACT_W-1:0]  m_act_reg;
    logic              out_load;

    logic [6:0]        eff_side;
    logic [TIDX_W-1:0] eff_ks;
    logic              s_accept;
    logic              in_map;
    logic              tap_ok;
    logic              mac_clr;
    logic              last_l, last_tap;
    logic [6:0]        row_sum, col_sum, pr, pc;
    logic [8:0]        bound;
    logic              bound_ok, pix_in;

    store_wr_t                wr;
    logic [PIX_AW-1:0]        pix_raddr;
    logic [TAP_AW-1:0]        tap_raddr;
    logic [PIX_W-1:0]         pix_rdata;
    logic signed [COEF_W-1:0] w_rdata, b_rdata;
    logic                     clr_busy;
    logic [PIX_W-1:0]         mac_pixel;
    logic signed [ACC_W-1:0]  acc;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_side_reg  <= 7'd64;
            kernel_side_reg <= 4'd3;
            pad_reg         <= 7'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_IMAGE_SIDE:  image_side_reg  <= cfg_data;
                CFG_KERNEL_SIDE: kernel_side_reg <= cfg_data[TIDX_W-1:0];
                CFG_PAD_AMOUNT:  pad_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_side = (image_side_reg > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : image_side_reg;
    assign eff_ks   = (kernel_side_reg > TIDX_W'(MAX_KERNEL_SIDE))
                    ? TIDX_W'(MAX_KERNEL_SIDE) : kernel_side_reg;

    // input side and store writes
    assign s_ready  = (state_reg == ST_IDLE) && !clr_busy;
    assign s_accept = s_valid && s_ready;
    assign in_map   = (7'(s_row_index) < eff_side) && (7'(s_col_index) < eff_side);
    assign tap_ok   = (s_row_index < POS_W'(MAX_KERNEL_SIDE))
                   && (s_col_index < POS_W'(MAX_KERNEL_SIDE));

    always_comb begin
        wr          = '0;
        wr.pix_addr = {s_row_index, s_col_index};
        wr.tap_addr = tap_addr(s_kernel_index, s_row_index[TIDX_W-1:0],
                               s_col_index[TIDX_W-1:0]);
        wr.data     = s_load_value;
        if (s_accept) begin
            unique case (op_t'(s_operation))
                OP_LOAD_PIXEL:  wr.pix_we = 1'b1;
                OP_LOAD_WEIGHT: wr.w_we   = tap_ok;
                OP_LOAD_BIAS:   wr.b_we   = tap_ok;
                OP_COMPUTE:     ;
                default:        ;
            endcase
        end
    end

    // tap address generation
    assign row_sum  = 7'(row_reg) + 7'(l_reg);
    assign col_sum  = 7'(col_reg) + 7'(h_reg);
    assign bound    = 9'(eff_side) + 9'({pad_reg, 1'b0});
    assign bound_ok = (9'(row_sum) < bound) && (9'(col_sum) < bound);
    assign pr       = row_sum - pad_reg;
    assign pc       = col_sum - pad_reg;
    assign pix_in   = (row_sum >= pad_reg) && (pr < eff_side)
                   && (col_sum >= pad_reg) && (pc < eff_side);
    assign pix_raddr = {pr[POS_W-1:0], pc[POS_W-1:0]};
    assign tap_raddr = row_base_reg + TAP_AW'(l_reg);
    assign last_l    = (l_reg == eff_ks - 1'b1);
    assign last_tap  = last_l && (h_reg == eff_ks - 1'b1);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        h_next         = h_reg;
        l_next         = l_reg;
        row_base_next  = row_base_reg;
        drain_next     = drain_reg;
        s1_valid_next  = 1'b0;
        s1_pix_in_next = 1'b0;
        mac_clr        = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && op_t'(s_operation) == OP_COMPUTE && in_map) begin
                    k_next        = s_kernel_index;
                    row_next      = s_row_index;
                    col_next      = s_col_index;
                    h_next        = '0;
                    l_next        = '0;
                    row_base_next = tap_addr(s_kernel_index, '0, '0);
                    drain_next    = 1'b0;
                    mac_clr       = 1'b1;
                    state_next    = (eff_ks == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                s1_valid_next  = bound_ok;
                s1_pix_in_next = pix_in;
                if (last_l) begin
                    l_next        = '0;
                    h_next        = h_reg + 1'b1;
                    row_base_next = row_base_reg + TAP_AW'(MAX_KERNEL_SIDE);
                end else begin
                    l_next = l_reg + 1'b1;
                end
                if (last_tap) begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // memory read stage, then product stage
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            drain_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_pix_in_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            drain_reg     <= drain_next;
            s1_valid_reg  <= s1_valid_next;
            s1_pix_in_reg <= s1_pix_in_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        h_reg        <= h_next;
        l_reg        <= l_next;
        row_base_reg <= row_base_next;
    end

    cdzr_stores u_stores (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .pix_raddr (pix_raddr),
        .tap_raddr (tap_raddr),
        .pix_rdata (pix_rdata),
        .w_rdata   (w_rdata),
        .b_rdata   (b_rdata),
        .clr_busy  (clr_busy)
    );

    // border taps multiply a zero pixel
    assign mac_pixel = s1_pix_in_reg ? pix_rdata : '0;

    cdzr_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clr      (mac_clr),
        .in_valid (s1_valid_reg),
        .pixel    (mac_pixel),
        .weight   (w_rdata),
        .bias     (b_rdata),
        .acc      (acc)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // drop negative sums; the sum bound keeps positive ones within 31 bits
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_kernel_reg <= k_reg;
            m_row_reg    <= row_reg;
            m_col_reg    <= col_reg;
            m_act_reg    <= acc[ACC_W-1] ? '0 : acc[ACT_W-1:0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_kernel = m_kernel_reg;
    assign m_out_row    = m_row_reg;
    assign m_out_col    = m_col_reg;
    assign m_activation = m_act_reg;

    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && !m_valid_reg) |=> m_valid_reg)
        else $error("finished sum not moved into output register");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result shown without a finished compute");

    a_no_tap_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> (!s1_valid_reg && state_reg == ST_IDLE))
        else $error("tap issued during store clearing sweep");

endmodule

// ----- src/cdzr_stores.sv -----
// Pixel, weight and bias memories with the post-reset clearing sweep of the tap stores.
module cdzr_stores (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cdzr_pkg::store_wr_t                wr,
    input  logic [cdzr_pkg::PIX_AW-1:0]        pix_raddr,
    input  logic [cdzr_pkg::TAP_AW-1:0]        tap_raddr,
    output logic [cdzr_pkg::PIX_W-1:0]         pix_rdata,
    output logic signed [cdzr_pkg::COEF_W-1:0] w_rdata,
    output logic signed [cdzr_pkg::COEF_W-1:0] b_rdata,
    output logic                               clr_busy
);
    import cdzr_pkg::*;

    logic [PIX_W-1:0]         pix_mem_reg [PIX_DEPTH];
    logic signed [COEF_W-1:0] w_mem_reg   [TAP_DEPTH];
    logic signed [COEF_W-1:0] b_mem_reg   [TAP_DEPTH];
    logic [PIX_W-1:0]         pix_q_reg;
    logic signed [COEF_W-1:0] w_q_reg;
    logic signed [COEF_W-1:0] b_q_reg;

    logic              clr_busy_reg, clr_busy_next;
    logic [TAP_AW-1:0] clr_addr_reg, clr_addr_next;

    logic                     w_we, b_we;
    logic [TAP_AW-1:0]        t_waddr;
    logic signed [COEF_W-1:0] t_wdata;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == TAP_AW'(TAP_DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // sweep zeros into both tap stores until every entry is written once
    assign w_we    = clr_busy_reg | wr.w_we;
    assign b_we    = clr_busy_reg | wr.b_we;
    assign t_waddr = clr_busy_reg ? clr_addr_reg : wr.tap_addr;
    assign t_wdata = clr_busy_reg ? '0 : wr.data;

    always_ff @(posedge aclk) begin
        if (wr.pix_we) begin
            pix_mem_reg[wr.pix_addr] <= wr.data[PIX_W-1:0];
        end
        pix_q_reg <= pix_mem_reg[pix_raddr];
    end

    always_ff @(posedge aclk) begin
        if (w_we) begin
            w_mem_reg[t_waddr] <= t_wdata;
        end
        w_q_reg <= w_mem_reg[tap_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem_reg[t_waddr] <= t_wdata;
        end
        b_q_reg <= b_mem_reg[tap_raddr];
    end

    assign pix_rdata = pix_q_reg;
    assign w_rdata   = w_q_reg;
    assign b_rdata   = b_q_reg;
    assign clr_busy  = clr_busy_reg;

endmodule

// ----- src/cdzr_mac.sv -----
// Shared multiply-accumulate unit: registered pixel*weight product, then sum with bias.
module cdzr_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               clr,
    input  logic                               in_valid,
    input  logic [cdzr_pkg::PIX_W-1:0]         pixel,
    input  logic signed [cdzr_pkg::COEF_W-1:0] weight,
    input  logic signed [cdzr_pkg::COEF_W-1:0] bias,
    output logic signed [cdzr_pkg::ACC_W-1:0]  acc
);
    import cdzr_pkg::*;

    logic signed [PIX_W:0]    pix_s;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic signed [COEF_W-1:0] bias_reg;
    logic                     pv_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    assign pix_s     = $signed({1'b0, pixel});
    assign prod_next = PROD_W'(pix_s) * PROD_W'(weight);
    assign acc_next  = acc_reg + ACC_W'(prod_reg) + ACC_W'(bias_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        bias_reg <= bias;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end else if (clr) begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            pv_reg <= in_valid;
            if (pv_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign acc = acc_reg;

endmodule
